// ----- sv/hlfl_pkg.sv -----
// Package for the header line field locator: widths, codes and helper functions.
`timescale 1ns / 1ps

package hlfl_pkg;

    localparam int FIELD_W  = 14;
    localparam int POS_W    = FIELD_W;
    localparam int MAX_LINE = 8192;
    localparam logic [POS_W-1:0] LINE_LIMIT = POS_W'(MAX_LINE);

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_MALFORMED   = 2'd1,
        ST_END_HEADERS = 2'd2,
        ST_TOO_LONG    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_NAME_LIMIT  = 2'd0,
        REG_VALUE_LIMIT = 2'd1
    } reg_index_t;

    // Positions collected for one finished line.
    typedef struct packed {
        logic             overflowed;
        logic             eoh;
        logic             colon_seen;
        logic [POS_W-1:0] colon_position;
        logic             value_started;
        logic [POS_W-1:0] value_start;
        logic [POS_W-1:0] value_end;
        logic [POS_W-1:0] line_len;
    } line_sum_t;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // Zero limit behaves as one.
    function automatic logic [FIELD_W-1:0] clamp_len(input logic [FIELD_W-1:0] len,
                                                     input logic [FIELD_W-1:0] limit);
        logic [FIELD_W-1:0] lim;
        lim = (limit == '0) ? FIELD_W'(1) : limit;
        clamp_len = (len >= lim) ? (lim - FIELD_W'(1)) : len;
    endfunction

endpackage

// ----- sv/hlfl_line_tracker.sv -----
// Per-byte line state tracker with a registered line summary stage.
`timescale 1ns / 1ps

module hlfl_line_tracker import hlfl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] in_byte,
    input  logic      in_last,
    output line_sum_t sum,
    output logic      sum_valid,
    input  logic      sum_ready
);

    logic [POS_W-1:0] byte_count_reg, byte_count_next;
    logic             colon_seen_reg, colon_seen_next;
    logic [POS_W-1:0] colon_position_reg, colon_position_next;
    logic             value_started_reg, value_started_next;
    logic [POS_W-1:0] value_start_reg, value_start_next;
    logic [POS_W-1:0] value_end_reg, value_end_next;
    logic             first_was_cr_reg, first_was_cr_next;
    logic             overflowed_reg, overflowed_next;
    logic             sum_valid_reg, sum_valid_next;
    line_sum_t        sum_reg, sum_next;
    logic             eoh;
    logic             accept;
    logic [POS_W-1:0] pos_inc;

    assign in_ready  = !sum_valid_reg || sum_ready;
    assign accept    = in_valid && in_ready;
    assign sum       = sum_reg;
    assign sum_valid = sum_valid_reg;
    assign pos_inc   = byte_count_reg + POS_W'(1);

    always_comb begin
        byte_count_next     = byte_count_reg;
        colon_seen_next     = colon_seen_reg;
        colon_position_next = colon_position_reg;
        value_started_next  = value_started_reg;
        value_start_next    = value_start_reg;
        value_end_next      = value_end_reg;
        first_was_cr_next   = first_was_cr_reg;
        overflowed_next     = overflowed_reg;
        eoh                 = 1'b0;

        if (byte_count_reg == LINE_LIMIT) begin
            overflowed_next = 1'b1;
        end else begin
            if (byte_count_reg == '0) begin
                first_was_cr_next = (in_byte == CHAR_CR);
            end
            eoh = (byte_count_reg == POS_W'(1)) && first_was_cr_reg && (in_byte == CHAR_LF);
            if (!colon_seen_reg) begin
                if (in_byte == CHAR_COLON) begin
                    colon_seen_next     = 1'b1;
                    colon_position_next = byte_count_reg;
                end
            end else if (!is_ws(in_byte)) begin
                if (!value_started_reg) begin
                    value_started_next = 1'b1;
                    value_start_next   = byte_count_reg;
                end
                value_end_next = pos_inc;
            end
            byte_count_next = pos_inc;
        end

        sum_next.overflowed     = overflowed_next;
        sum_next.eoh            = eoh;
        sum_next.colon_seen     = colon_seen_next;
        sum_next.colon_position = colon_position_next;
        sum_next.value_started  = value_started_next;
        sum_next.value_start    = value_start_next;
        sum_next.value_end      = value_end_next;
        sum_next.line_len       = byte_count_next;

        sum_valid_next = sum_valid_reg && !sum_ready;
        if (accept && in_last) begin
            sum_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg     <= '0;
            colon_seen_reg     <= 1'b0;
            colon_position_reg <= '0;
            value_started_reg  <= 1'b0;
            value_start_reg    <= '0;
            value_end_reg      <= '0;
            first_was_cr_reg   <= 1'b0;
            overflowed_reg     <= 1'b0;
            sum_valid_reg      <= 1'b0;
        end else begin
            sum_valid_reg <= sum_valid_next;
            if (accept) begin
                if (in_last) begin
                    byte_count_reg     <= '0;
                    colon_seen_reg     <= 1'b0;
                    colon_position_reg <= '0;
                    value_started_reg  <= 1'b0;
                    value_start_reg    <= '0;
                    value_end_reg      <= '0;
                    first_was_cr_reg   <= 1'b0;
                    overflowed_reg     <= 1'b0;
                end else begin
                    byte_count_reg     <= byte_count_next;
                    colon_seen_reg     <= colon_seen_next;
                    colon_position_reg <= colon_position_next;
                    value_started_reg  <= value_started_next;
                    value_start_reg    <= value_start_next;
                    value_end_reg      <= value_end_next;
                    first_was_cr_reg   <= first_was_cr_next;
                    overflowed_reg     <= overflowed_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && in_last) begin
            sum_reg <= sum_next;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= LINE_LIMIT)
        else $error("byte counter past line limit");

    a_value_after_colon: assert property (@(posedge aclk) disable iff (!aresetn)
        value_started_reg |-> colon_seen_reg && (value_end_reg > value_start_reg)
                              && (value_start_reg > colon_position_reg))
        else $error("value positions inconsistent");

    a_sum_held: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_valid_reg && !sum_ready |=> sum_valid_reg && $stable(sum_reg))
        else $error("line summary lost while stalled");

endmodule

// ----- sv/header_line_field_locator.sv -----
// Top level of the header line field locator: config registers and result stage.
`timescale 1ns / 1ps

// Takes one header line byte per cycle on the s_ stream (s_tlast on the line's final byte)
// and returns one request per line on the m_ stream, through the tracker's line summary register
// and then the output register. The line tracker updates its counters and positions as each byte
// is taken, so the sustained rate is one byte per clock; s_tready drops only while an untaken
// result sits in the output register and another finished line waits behind it. The result
// carries the status in m_tuser and the name length, value offset and trimmed value length in
// m_tdata; the bytes themselves are not stored. The user must write name_limit and value_limit
// through the cfg_ port while no line is in flight; the block itself does not enforce this.

module header_line_field_locator import hlfl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [FIELD_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] line_byte
    input  logic               s_tlast,   // last_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,   // [13:0] name_length, [27:14] value_offset,
                                          // [41:28] value_length, [47:42] zero
    output logic [1:0]         m_tuser    // [1:0] status
);

    logic [FIELD_W-1:0] name_limit_reg, value_limit_reg;
    line_sum_t          sum;
    logic               sum_valid;
    logic               out_free;
    logic               m_valid_reg, m_valid_next;
    status_t            status_reg, status_next;
    logic [FIELD_W-1:0] name_length_reg, name_length_next;
    logic [FIELD_W-1:0] value_offset_reg, value_offset_next;
    logic [FIELD_W-1:0] value_length_reg, value_length_next;

    hlfl_line_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .sum       (sum),
        .sum_valid (sum_valid),
        .sum_ready (out_free)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_limit_reg  <= FIELD_W'(256);
            value_limit_reg <= FIELD_W'(4096);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NAME_LIMIT:  name_limit_reg  <= cfg_wdata;
                REG_VALUE_LIMIT: value_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        status_next       = ST_OK;
        name_length_next  = '0;
        value_offset_next = '0;
        value_length_next = '0;
        if (sum.overflowed) begin
            status_next = ST_TOO_LONG;
        end else if (sum.eoh && (sum.line_len == POS_W'(2))) begin
            status_next = ST_END_HEADERS;
        end else if (!sum.colon_seen || (sum.colon_position == '0)) begin
            status_next = ST_MALFORMED;
        end else begin
            name_length_next = clamp_len(sum.colon_position, name_limit_reg);
            if (sum.value_started) begin
                value_offset_next = sum.value_start;
                value_length_next = clamp_len(sum.value_end - sum.value_start,
                                              value_limit_reg);
            end else begin
                value_offset_next = sum.line_len;
            end
        end
        m_valid_next = out_free ? sum_valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && sum_valid) begin
            status_reg       <= status_next;
            name_length_reg  <= name_length_next;
            value_offset_reg <= value_offset_next;
            value_length_reg <= value_length_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'd0, value_length_reg, value_offset_reg, name_length_reg};

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (status_reg != ST_OK) |->
            (name_length_reg == '0) && (value_offset_reg == '0) && (value_length_reg == '0))
        else $error("non-ok result with nonzero fields");

    a_name_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (status_reg == ST_OK) |->
            (name_length_reg < name_limit_reg) || (name_length_reg == '0))
        else $error("name length not clamped");

    a_value_after_name: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (status_reg == ST_OK) |-> value_offset_reg > name_length_reg)
        else $error("value offset not past name");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the header line field locator: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module testbench import hlfl_pkg::*; ();

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } line_byte_t;

    typedef struct packed {
        status_t            status;
        logic [FIELD_W-1:0] name_size;
        logic [FIELD_W-1:0] value_off;
        logic [FIELD_W-1:0] value_size;
    } line_fields_t;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [FIELD_W-1:0] cfg_wdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [47:0]        m_tdata;
    logic [1:0]         m_tuser;

    line_byte_t   line_bytes_q[$];
    line_fields_t expected_fields_q[$];
    line_byte_t   next_byte;
    line_byte_t   tail_byte;

    int error_count = 0;
    int queued_count = 0;
    int idle_mode = 1;
    int tx_gap = 0;
    int rx_gap = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    logic rx_hold_go = 1'b0;

    // shadow of the limit registers
    int name_limit_m = 256;
    int value_limit_m = 4096;

    // line tracking state
    int lb_count = 0;
    bit lb_colon = 0;
    int lb_colon_pos = 0;
    bit lb_val_started = 0;
    int lb_val_start = 0;
    int lb_val_end = 0;
    bit lb_first_cr = 0;
    bit lb_overflow = 0;

    header_line_field_locator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic bit blank_char(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic int fit_to_buffer(input int len, input int limit);
        int cap;
        cap = (limit == 0) ? 1 : limit;
        return (len >= cap) ? cap - 1 : len;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0 || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic track_line_byte(input logic [7:0] c, input logic last);
        int pos;
        bit eoh;
        line_fields_t r;
        pos = lb_count;
        eoh = 0;
        if (pos >= MAX_LINE) begin
            lb_overflow = 1;
        end else begin
            if (pos == 0) lb_first_cr = (c == CHAR_CR);
            if (pos == 1 && lb_first_cr && c == CHAR_LF) eoh = 1;
            if (!lb_colon) begin
                if (c == CHAR_COLON) begin
                    lb_colon = 1;
                    lb_colon_pos = pos;
                end
            end else if (!blank_char(c)) begin
                if (!lb_val_started) begin
                    lb_val_started = 1;
                    lb_val_start = pos;
                end
                lb_val_end = pos + 1;
            end
            lb_count = pos + 1;
        end
        if (last) begin
            r.status = ST_OK;
            r.name_size = '0;
            r.value_off = '0;
            r.value_size = '0;
            if (lb_overflow) begin
                r.status = ST_TOO_LONG;
            end else if (eoh && lb_count == 2) begin
                r.status = ST_END_HEADERS;
            end else if (!lb_colon || lb_colon_pos == 0) begin
                r.status = ST_MALFORMED;
            end else begin
                r.name_size = FIELD_W'(fit_to_buffer(lb_colon_pos, name_limit_m));
                if (lb_val_started) begin
                    r.value_off = FIELD_W'(lb_val_start);
                    r.value_size = FIELD_W'(fit_to_buffer(lb_val_end - lb_val_start,
                                                          value_limit_m));
                end else begin
                    r.value_off = FIELD_W'(lb_count);
                end
            end
            expected_fields_q.push_back(r);
            lb_count = 0;
            lb_colon = 0;
            lb_colon_pos = 0;
            lb_val_started = 0;
            lb_val_start = 0;
            lb_val_end = 0;
            lb_first_cr = 0;
            lb_overflow = 0;
        end
    endtask

    task automatic check_line_fields();
        line_fields_t want;
        if (expected_fields_q.size() == 0) begin
            report_error($sformatf("unexpected result, tuser %0d tdata %h", m_tuser, m_tdata));
            return;
        end
        want = expected_fields_q.pop_front();
        if (m_tuser != want.status)
            report_error($sformatf("status got %0d want %0d", m_tuser, want.status));
        if (m_tdata[13:0] != want.name_size)
            report_error($sformatf("name_length got %0d want %0d", m_tdata[13:0],
                                   want.name_size));
        if (m_tdata[27:14] != want.value_off)
            report_error($sformatf("value_offset got %0d want %0d", m_tdata[27:14],
                                   want.value_off));
        if (m_tdata[41:28] != want.value_size)
            report_error($sformatf("value_length got %0d want %0d", m_tdata[41:28],
                                   want.value_size));
        if (m_tdata[47:42] != '0)
            report_error($sformatf("tdata padding not zero: %h", m_tdata[47:42]));
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) track_line_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (line_bytes_q.size() != 0) begin
                    next_byte = line_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_byte.data;
                    s_tlast <= next_byte.last;
                    tx_gap = idle_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_tvalid && m_tready) check_line_fields();
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_gap = idle_gap();
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (rx_hold_go) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            name_limit_m <= 256;
            value_limit_m <= 4096;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NAME_LIMIT:  name_limit_m <= int'(cfg_wdata);
                REG_VALUE_LIMIT: value_limit_m <= int'(cfg_wdata);
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", stall_cycles);
            $display("** header_line_field_locator: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_byte(input logic [7:0] c);
        line_byte_t b;
        b.data = c;
        b.last = 1'b0;
        line_bytes_q.push_back(b);
        queued_count++;
    endtask

    task automatic end_line();
        tail_byte = line_bytes_q.pop_back();
        tail_byte.last = 1'b1;
        line_bytes_q.push_back(tail_byte);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CHAR_SPACE : CHAR_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] pick_name_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CHAR_COLON) ? 8'h41 : c;
    endfunction

    task automatic build_random_line();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
            add_byte(CHAR_COLON);
            repeat ($urandom_range(0, 2)) add_byte(pick_blank());
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
            repeat (n) begin
                if ($urandom_range(0, 9) < 3) add_byte(pick_blank());
                else add_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 2)) add_byte(pick_blank());
            if ($urandom_range(0, 9) < 6) begin
                add_byte(CHAR_CR);
                add_byte(CHAR_LF);
            end
        end else if (kind < 78) begin
            add_byte(CHAR_CR);
            add_byte(CHAR_LF);
        end else if (kind < 88) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
        end else if (kind < 94) begin
            if ($urandom_range(0, 1) == 1) add_byte(CHAR_COLON);
            repeat ($urandom_range(1, 6)) add_byte(pick_name_char());
            if ($urandom_range(0, 1) == 1) add_byte(CHAR_CR);
        end else begin
            repeat ($urandom_range(1, 5)) add_byte(pick_name_char());
            add_byte(CHAR_COLON);
            repeat ($urandom_range(0, 4)) add_byte(pick_blank());
        end
        end_line();
    endtask

    task automatic build_long_line(input int name_chars, input int total);
        for (int i = 0; i < name_chars; i++) add_byte(pick_name_char());
        add_byte(CHAR_COLON);
        for (int i = name_chars + 1; i < total; i++) add_byte(8'($urandom_range(0, 255)));
        end_line();
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [FIELD_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (line_bytes_q.size() != 0 || s_tvalid || expected_fields_q.size() != 0);
        repeat (6) @(negedge aclk);
    endtask

    task automatic run_phase(input int nl, input int vl, input int mode, input int nbytes,
                             input bit hold_rx);
        int goal;
        write_reg(REG_NAME_LIMIT, FIELD_W'(nl));
        write_reg(REG_VALUE_LIMIT, FIELD_W'(vl));
        @(negedge aclk);
        idle_mode = mode;
        goal = queued_count + nbytes;
        while (queued_count < goal) build_random_line();
        if (hold_rx) begin
            @(posedge aclk);
            rx_hold_go <= 1'b1;
            @(posedge aclk);
            rx_hold_go <= 1'b0;
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed lines at reset limits
        add_byte(CHAR_CR); add_byte(CHAR_LF); end_line();
        add_str("A"); end_line();
        add_str(":v"); end_line();
        add_str("a:b"); end_line();
        add_str("Ab:"); add_byte(CHAR_TAB); add_byte(CHAR_SPACE); end_line();
        add_byte(8'hFF); add_byte(8'h00); add_str(": v");
        add_byte(8'h0E); add_byte(8'h08); add_byte(CHAR_CR); add_byte(CHAR_LF); end_line();
        add_byte(CHAR_CR); add_byte(CHAR_LF); add_str(" x"); end_line();
        wait_drained();

        run_phase(1, 1, 1, 130, 0);
        run_phase(0, 0, 1, 110, 0);
        run_phase(3, 5, 1, 130, 0);
        run_phase(16383, 16383, 1, 110, 0);
        run_phase(8192, 8192, 0, 100, 0);

        // longest lines: exactly at the limit, one past it, colon beyond it
        write_reg(REG_NAME_LIMIT, FIELD_W'(256));
        write_reg(REG_VALUE_LIMIT, FIELD_W'(4096));
        @(negedge aclk);
        idle_mode = 1;
        repeat (10) build_random_line();
        build_long_line(300, MAX_LINE);
        build_long_line(50, MAX_LINE + 1);
        build_long_line(MAX_LINE + 5, MAX_LINE + 40);
        repeat (10) build_random_line();
        wait_drained();

        run_phase(20, 12, 0, 200, 1);
        run_phase($urandom_range(1, 40), $urandom_range(1, 40), 1, 120, 0);

        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("** header_line_field_locator: PASSED **");
        end else begin
            $display("** header_line_field_locator: FAILED **");
        end
        $finish;
    end

endmodule
